// ===== src/modexp_pkg.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and control types for the modulo-1000000007 exponentiator.
// ---------------------------------------------------------------------------
package modexp_pkg;

   // Field widths of the transfer payloads.
   localparam int BASE_W = 31;
   localparam int RES_W  = 30;

   // The prime modulus and the fixed exponent that yields the inverse.
   localparam logic [RES_W-1:0] MODULUS      = 30'd1000000007;
   localparam logic [RES_W-1:0] INV_EXPONENT = 30'd1000000005;

   // Barrett constant floor(2^60 / MODULUS), used by the multiplier.
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(MODULUS));

   // Operation codes.
   localparam logic OP_POWER   = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic start_mul;
      logic update;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exp_zero;
      logic mul_done;
   } dp_status_type;

endpackage

// ===== src/modexp_if.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for the request and the response of the block.
// ---------------------------------------------------------------------------

// Request channel: operation, base and exponent.
interface modexp_req_if #(
   parameter int EXP_BITS = 63
);
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [modexp_pkg::BASE_W-1:0] base_value;
   logic [EXP_BITS-1:0]           exponent_value;

   modport source (output valid, output operation, output base_value,
                   output exponent_value, input ready);
   modport sink   (input valid, input operation, input base_value,
                   input exponent_value, output ready);
endinterface

// Response channel: one residue per request.
interface modexp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [modexp_pkg::RES_W-1:0] residue;

   modport source (output valid, output residue, input ready);
   modport sink   (input valid, input residue, output ready);
endinterface

// ===== src/modular_exponentiation.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation
// Square-and-multiply exponentiator and inverter modulo 1000000007.
// ---------------------------------------------------------------------------
// Each request yields one residue. A request runs one round for every
// exponent bit up to and including its highest set bit; an inverse uses
// the 30-bit exponent 1000000005, and a zero exponent runs no round. The
// round time is set by the four-stage Barrett modular multipliers, which
// square the running base and multiply it into the accumulator in
// parallel. One request is in flight at a time; a finished residue sits in
// an output register, so the next request is taken while it waits to be
// read.
module modular_exponentiation #(
   parameter int EXP_BITS = 63
) (
   input  logic         clock,
   input  logic         reset,
   modexp_req_if.sink   req_ch,
   modexp_rsp_if.source rsp_ch
);

   modexp_pkg::ctrl_cmd_type  cmd;
   modexp_pkg::dp_status_type status;

   // Round sequencing and handshakes.
   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and operand registers.
   modexp_datapath #(
      .EXP_BITS (EXP_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .operation      (req_ch.operation),
      .base_value     (req_ch.base_value),
      .exponent_value (EXP_BITS'(req_ch.exponent_value)),
      .cmd            (cmd),
      .status         (status),
      .residue        (rsp_ch.residue)
   );

`ifndef SYNTHESIS
   // Operands are loaded only on a request transfer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_ch.valid && req_ch.ready))
      else $error("operand load without a request transfer");

   // A new residue never overwrites one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pending residue overwritten");

   // No multiplication round is started once the exponent is exhausted.
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_mul |-> !status.exp_zero)
      else $error("round started with a zero exponent");

   // Every delivered residue is fully reduced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.residue < modexp_pkg::MODULUS))
      else $error("residue not below the modulus");
`endif

endmodule

// ===== src/modexp_mulmod.sv =====
// ---------------------------------------------------------------------------
// Modular multiplier
// Four-stage pipelined a*b mod MODULUS using Barrett reduction.
// ---------------------------------------------------------------------------
module modexp_mulmod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [modexp_pkg::RES_W-1:0] a_value,
   input  logic [modexp_pkg::RES_W-1:0] b_value,
   output logic                         done,
   output logic [modexp_pkg::RES_W-1:0] product_mod
);

   logic [3:0]  vld_ff,  vld_in;
   logic [59:0] x_ff,    x_in;
   logic [61:0] q2_ff,   q2_in;
   logic [31:0] xlo_ff,  xlo_in;
   logic [31:0] rem_ff,  rem_in;
   logic [modexp_pkg::RES_W-1:0] res_ff, res_in;
   logic [30:0] q3;
   logic [31:0] qp_low;
   logic [31:0] p32;
   logic [31:0] two_p;

   // Stage 1: the full product, below 2^60 since both operands are reduced.
   assign x_in = {30'd0, a_value} * {30'd0, b_value};

   // Stage 2: quotient estimate from the top bits of the product.
   assign q2_in  = {31'd0, x_ff[59:29]} * {31'd0, modexp_pkg::BARRETT_MU};
   assign xlo_in = x_ff[31:0];

   // Stage 3: the remainder estimate, below three moduli, fits in 32 bits.
   assign q3     = q2_ff[61:31];
   assign qp_low = 32'(q3) * 32'(modexp_pkg::MODULUS);
   assign rem_in = xlo_ff - qp_low;

   // Stage 4: at most two subtractions of the modulus finish the reduction.
   assign p32   = {2'b00, modexp_pkg::MODULUS};
   assign two_p = {1'b0, modexp_pkg::MODULUS, 1'b0};

   always_comb begin
      priority if (rem_ff >= two_p) begin
         res_in = modexp_pkg::RES_W'(rem_ff - two_p);
      end else if (rem_ff >= p32) begin
         res_in = modexp_pkg::RES_W'(rem_ff - p32);
      end else begin
         res_in = modexp_pkg::RES_W'(rem_ff);
      end
   end

   // Valid bits travel alongside the data.
   assign vld_in = {vld_ff[2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      q2_ff  <= q2_in;
      xlo_ff <= xlo_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done        = vld_ff[3];
   assign product_mod = res_ff;

endmodule

// ===== src/modexp_datapath.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the accumulator, running square and exponent of the current request.
// ---------------------------------------------------------------------------
module modexp_datapath #(
   parameter int EXP_BITS = 63
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          operation,
   input  logic [modexp_pkg::BASE_W-1:0] base_value,
   input  logic [EXP_BITS-1:0]           exponent_value,
   input  modexp_pkg::ctrl_cmd_type      cmd,
   output modexp_pkg::dp_status_type     status,
   output logic [modexp_pkg::RES_W-1:0]  residue
);

   localparam int InvW = modexp_pkg::RES_W;
   localparam int ExpW = (EXP_BITS > InvW) ? EXP_BITS : InvW;

   logic [modexp_pkg::RES_W-1:0] acc_ff, acc_in;
   logic [modexp_pkg::RES_W-1:0] sq_ff,  sq_in;
   logic [ExpW-1:0]              exp_ff, exp_in;
   logic [modexp_pkg::RES_W-1:0] residue_ff, residue_in;
   logic [modexp_pkg::RES_W-1:0] acc_prod, sq_prod;
   logic [modexp_pkg::RES_W-1:0] base_red;
   logic [ExpW-1:0]              exp_load;
   logic [modexp_pkg::BASE_W-1:0] p31, two_p31;
   logic                         acc_done, sq_done;

   // The base is below three moduli, so two compares reduce it.
   assign p31     = {1'b0, modexp_pkg::MODULUS};
   assign two_p31 = {modexp_pkg::MODULUS, 1'b0};

   always_comb begin
      priority if (base_value >= two_p31) begin
         base_red = modexp_pkg::RES_W'(base_value - two_p31);
      end else if (base_value >= p31) begin
         base_red = modexp_pkg::RES_W'(base_value - p31);
      end else begin
         base_red = modexp_pkg::RES_W'(base_value);
      end
   end

   // The inverse uses the prime minus two as its exponent.
   always_comb begin
      unique case (operation)
         modexp_pkg::OP_INVERSE: exp_load = ExpW'(modexp_pkg::INV_EXPONENT);
         default:                exp_load = ExpW'(exponent_value);
      endcase
   end

   // Multiply and square run side by side each round.
   modexp_mulmod u_mul_acc (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.start_mul),
      .a_value     (acc_ff),
      .b_value     (sq_ff),
      .done        (acc_done),
      .product_mod (acc_prod)
   );

   modexp_mulmod u_mul_sq (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.start_mul),
      .a_value     (sq_ff),
      .b_value     (sq_ff),
      .done        (sq_done),
      .product_mod (sq_prod)
   );

   // Register updates for load, for the end of each round and for emit.
   always_comb begin
      acc_in     = acc_ff;
      sq_in      = sq_ff;
      exp_in     = exp_ff;
      residue_in = residue_ff;
      if (cmd.load) begin
         acc_in = modexp_pkg::RES_W'(1);
         sq_in  = base_red;
         exp_in = exp_load;
      end else if (cmd.update) begin
         acc_in = exp_ff[0] ? acc_prod : acc_ff;
         sq_in  = sq_prod;
         exp_in = exp_ff >> 1;
      end
      if (cmd.emit) begin
         residue_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      exp_ff     <= exp_in;
      residue_ff <= residue_in;
   end

   assign status.exp_zero = (exp_ff == '0);
   assign status.mul_done = acc_done & sq_done;
   assign residue         = residue_ff;

endmodule

// ===== src/modexp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences the square-and-multiply rounds and the response handshake.
// ---------------------------------------------------------------------------
module modexp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  modexp_pkg::dp_status_type status,
   output modexp_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_MUL    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.start_mul = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.mul_done) begin
               cmd.update = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The response register is filled by emit and freed by a transfer.
   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives power and inverse requests into the exponentiator, first from a
// table of corner cases and then at random. Each residue is checked against
// a pinned value or a square-and-multiply predictor; the random requests run
// in four mixes of sender and receiver idling.
// ---------------------------------------------------------------------------
module tb;

   localparam int EXP_BITS = 63;
   localparam int BASE_W = modexp_pkg::BASE_W;
   localparam int RES_W = modexp_pkg::RES_W;
   // Drain time: covers the slowest request, with some margin.
   localparam int DRAIN_CYCLES = 5 * EXP_BITS + 20;
   localparam int RANDOM_PER_PHASE = 332;
   localparam int DIRECTED_ROWS = 24;
   localparam logic [EXP_BITS-1:0] EXP_ALL_ONES = '1;

   // One row of the directed table; the residue is used only when pinned.
   typedef struct packed {
      logic                op;
      logic [BASE_W-1:0]   base;
      logic [EXP_BITS-1:0] expo;
      logic                pinned;
      logic [RES_W-1:0]    residue;
   } request_row_type;

   logic clock = 1'b0;
   logic reset;

   modexp_req_if #(.EXP_BITS(EXP_BITS)) req_ch ();
   modexp_rsp_if rsp_ch ();

   modular_exponentiation #(.EXP_BITS(EXP_BITS)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Residues still owed by the block, oldest first.
   logic [RES_W-1:0] pending_residues[$];
   int mismatch_count = 0;
   int power_count = 0;
   int inverse_count = 0;
   int residue_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Corner cases: zero exponents, multiples of the prime, base of one,
   // reduced and unreduced bases, and exponent extremes.
   request_row_type corner_rows [0:DIRECTED_ROWS-1] = '{
      '{modexp_pkg::OP_POWER,   31'd0,          63'd0,        1'b1, 30'd1},
      '{modexp_pkg::OP_POWER,   31'h7FFFFFFF,   63'd0,        1'b1, 30'd1},
      '{modexp_pkg::OP_POWER,   31'd0,          63'd1,        1'b1, 30'd0},
      '{modexp_pkg::OP_POWER,   31'd0,          EXP_ALL_ONES, 1'b1, 30'd0},
      '{modexp_pkg::OP_POWER,   31'd1000000007, 63'd5,        1'b1, 30'd0},
      '{modexp_pkg::OP_POWER,   31'd2000000014, EXP_ALL_ONES, 1'b1, 30'd0},
      '{modexp_pkg::OP_POWER,   31'd1,          EXP_ALL_ONES, 1'b1, 30'd1},
      '{modexp_pkg::OP_POWER,   31'd2,          63'd1,        1'b1, 30'd2},
      '{modexp_pkg::OP_POWER,   31'h7FFFFFFF,   63'd1,        1'b1, 30'd147483633},
      '{modexp_pkg::OP_POWER,   31'd1000000006, 63'd1,        1'b1, 30'd1000000006},
      '{modexp_pkg::OP_POWER,   31'd1000000006, 63'd2,        1'b1, 30'd1},
      '{modexp_pkg::OP_POWER,   31'd3,          63'd1000000006, 1'b1, 30'd1},
      '{modexp_pkg::OP_POWER,   31'h7FFFFFFF,   EXP_ALL_ONES, 1'b0, 30'd0},
      '{modexp_pkg::OP_POWER,   31'd2,          63'h4000000000000000, 1'b0, 30'd0},
      '{modexp_pkg::OP_POWER,   31'd5,          63'h5555555555555555, 1'b0, 30'd0},
      '{modexp_pkg::OP_POWER,   31'h2AAAAAAA,   63'h2AAAAAAAAAAAAAAA, 1'b0, 30'd0},
      '{modexp_pkg::OP_INVERSE, 31'd1,          EXP_ALL_ONES, 1'b1, 30'd1},
      '{modexp_pkg::OP_INVERSE, 31'd0,          63'd0,        1'b1, 30'd0},
      '{modexp_pkg::OP_INVERSE, 31'd1000000007, 63'd7,        1'b1, 30'd0},
      '{modexp_pkg::OP_INVERSE, 31'd2000000014, 63'd0,        1'b1, 30'd0},
      '{modexp_pkg::OP_INVERSE, 31'd2,          63'd3,        1'b1, 30'd500000004},
      '{modexp_pkg::OP_INVERSE, 31'd1000000006, 63'd0,        1'b1, 30'd1000000006},
      '{modexp_pkg::OP_INVERSE, 31'h7FFFFFFF,   EXP_ALL_ONES, 1'b0, 30'd0},
      '{modexp_pkg::OP_INVERSE, 31'h55555555,   63'h5555555555555555, 1'b0, 30'd0}
   };

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Square-and-multiply over the low exponent bits, lowest bit first.
   function automatic logic [RES_W-1:0] predict_residue(
         input logic op,
         input logic [BASE_W-1:0] base,
         input logic [EXP_BITS-1:0] expo);
      longint unsigned prime;
      longint unsigned acc;
      longint unsigned square;
      longint unsigned scan;
      int              nbits;
      prime = 64'(modexp_pkg::MODULUS);
      if (op == modexp_pkg::OP_INVERSE) begin
         if (base == 31'd1) return RES_W'(1);
         scan  = 64'(modexp_pkg::INV_EXPONENT);
         nbits = 64;
      end else begin
         scan  = 64'(expo);
         nbits = EXP_BITS;
      end
      acc    = 1;
      square = 64'(base) % prime;
      for (int i = 0; i < nbits; i++) begin
         if (scan[i]) acc = (acc * square) % prime;
         square = (square * square) % prime;
      end
      return RES_W'(acc);
   endfunction

   // Bases cluster around zero, the prime and its double, plus full range.
   function automatic logic [BASE_W-1:0] pick_base();
      longint unsigned prime;
      prime = 64'(modexp_pkg::MODULUS);
      case ($urandom_range(0, 5))
         0: return BASE_W'($urandom_range(0, 15));
         1: return BASE_W'(prime - 8 + $urandom_range(0, 16));
         2: return BASE_W'(prime * $urandom_range(0, 2));
         3: return BASE_W'(2 * prime + $urandom_range(0, 147483633));
         default: return BASE_W'($urandom);
      endcase
   endfunction

   // Exponents of random length with the top bit of that length set, so
   // that the block's run time is spread over its whole range.
   function automatic logic [EXP_BITS-1:0] pick_exponent();
      logic [63:0] raw;
      int          len;
      raw = {$urandom, $urandom};
      len = $urandom_range(0, EXP_BITS);
      if ($urandom_range(0, 9) == 0) return EXP_ALL_ONES;
      if (len == 0) return '0;
      raw = raw & ((64'd1 << len) - 64'd1);
      raw[len-1] = 1'b1;
      return raw[EXP_BITS-1:0];
   endfunction

   // Offer one request, idling first at random, and record the residue it
   // owes once the transfer has taken place.
   task automatic send_request(input logic op, input logic [BASE_W-1:0] base,
                               input logic [EXP_BITS-1:0] expo, input logic pinned,
                               input logic [RES_W-1:0] pinned_residue);
      logic [RES_W-1:0] owed;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.operation      <= op;
      req_ch.base_value     <= base;
      req_ch.exponent_value <= expo;
      do @(posedge clock); while (!req_ch.ready);
      owed = pinned ? pinned_residue : predict_residue(op, base, expo);
      pending_residues = {pending_residues, owed};
      if (op == modexp_pkg::OP_INVERSE) inverse_count++;
      else power_count++;
   endtask

   // Hold off the sender until every owed residue has come back.
   task automatic wait_for_residues();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_residues.size() != 0) @(posedge clock);
   endtask

   // Receiver readiness, stalling at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Compare each residue transfer with the oldest owed residue.
   always @(posedge clock) begin : check_residues
      logic [RES_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         residue_count++;
         if (pending_residues.size() == 0) begin
            $error("residue: expected none, actual %0d", rsp_ch.residue);
            mismatch_count++;
         end else begin
            want = pending_residues.pop_front();
            if (rsp_ch.residue !== want) begin
               $error("residue: expected %0d, actual %0d", want, rsp_ch.residue);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus: corner table without idling, then random requests in four
   // idling mixes, draining the block between mixes.
   initial begin : stimulus
      int send_mix [0:3];
      int recv_mix [0:3];
      logic op;
      send_mix = '{0, 70, 0, 21};
      recv_mix = '{0, 0, 70, 21};
      req_ch.valid          = 1'b0;
      req_ch.operation      = modexp_pkg::OP_POWER;
      req_ch.base_value     = '0;
      req_ch.exponent_value = '0;
      reset                 = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_rows[i]) begin
         send_request(corner_rows[i].op, corner_rows[i].base, corner_rows[i].expo,
                      corner_rows[i].pinned, corner_rows[i].residue);
      end
      wait_for_residues();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_mix[phase];
         recv_stall_pct = recv_mix[phase];
         repeat (RANDOM_PER_PHASE) begin
            op = ($urandom_range(0, 3) == 0) ? modexp_pkg::OP_INVERSE
                                             : modexp_pkg::OP_POWER;
            send_request(op, pick_base(), pick_exponent(), 1'b0, '0);
         end
         wait_for_residues();
      end

      // Let any stray residue show up before the verdict.
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d power and %0d inverse requests, %0d residues compared,",
               power_count, inverse_count, residue_count);
      $display("over a corner table and four mixes of sender idling and receiver stalls.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #20ms;
      $display("Timed out waiting for the block.");
      $display("Mismatches found");
      $finish;
   end
endmodule
